/* rtl/core/hbwd_pkg.sv */
// shared constants, codes and types for the heartbeat watchdog
package hbwd_pkg;

    localparam int CORES     = 64;
    localparam int ADDR_W    = $clog2(CORES);
    localparam int CNT_W     = $clog2(CORES + 1);

    localparam int ID_W      = 6;
    localparam int STAMP_W   = 64;
    localparam int MASK_W    = 64;
    localparam int FCNT_W    = 6;
    localparam int CCNT_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORE_COUNT = 2'd2;

    localparam logic [STAMP_W-1:0] THRESHOLD_RESET  = 64'd1000000000;
    localparam logic [CCNT_W-1:0]  CORE_COUNT_RESET = 7'd64;

    localparam logic CMD_PULSE = 1'b0;
    localparam logic CMD_SCAN  = 1'b1;

    typedef struct packed {
        logic               enable;
        logic [STAMP_W-1:0] threshold;
        logic [CCNT_W-1:0]  core_count;
    } cfg_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [STAMP_W-1:0] wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr;
    } ram_req_t;

endpackage

/* rtl/core/hbwd_if.sv */
// request and result channel interfaces of the heartbeat watchdog
interface hbwd_in_if import hbwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [ID_W-1:0]    core_id;
    logic [STAMP_W-1:0] now;

    modport source (output valid, output cmd, output core_id, output now, input ready);
    modport sink   (input valid, input cmd, input core_id, input now, output ready);
endinterface

interface hbwd_out_if import hbwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] failed_mask;
    logic [FCNT_W-1:0] failed_count;

    modport source (output valid, output failed_mask, output failed_count, input ready);
    modport sink   (input valid, input failed_mask, input failed_count, output ready);
endinterface

/* rtl/core/hbwd_ram.sv */
// generic single-write, single-read ram with registered read data
module hbwd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/hbwd_ctrl.sv */
// pulse and scan sequencer: table read-modify-write, valid bits, result register
module hbwd_ctrl import hbwd_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    hbwd_in_if.sink            hb_in,
    hbwd_out_if.source         hb_out,
    output ram_req_t           ram_req,
    input  logic [STAMP_W-1:0] ram_rdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [CORES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic               chk_vld_reg, chk_vld_next;
    logic               chk_hit_reg, chk_hit_next;
    logic [ADDR_W-1:0]  chk_idx_reg, chk_idx_next;
    logic [STAMP_W-1:0] now_reg, now_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [FCNT_W-1:0]  count_reg, count_next;
    logic               out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]  out_mask_reg, out_mask_next;
    logic [FCNT_W-1:0]  out_count_reg, out_count_next;

    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] age;
    logic               stale;
    logic               id_in_range;

    assign hb_in.ready         = (state_reg == S_IDLE);
    assign hb_out.valid        = out_valid_reg;
    assign hb_out.failed_mask  = out_mask_reg;
    assign hb_out.failed_count = out_count_reg;

    // entry without a valid bit reads as never seen
    assign stamp = chk_hit_reg ? ram_rdata : '0;
    assign age   = now_reg - stamp;
    assign stale = chk_vld_reg && (stamp != '0) && (age > cfg.threshold);

    assign id_in_range = ({1'b0, hb_in.core_id} < (ID_W + 1)'(CORES));

    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        chk_vld_next   = 1'b0;
        chk_hit_next   = chk_hit_reg;
        chk_idx_next   = chk_idx_reg;
        now_next       = now_reg;
        mask_next      = mask_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !hb_out.ready;
        out_mask_next  = out_mask_reg;
        out_count_next = out_count_reg;

        ram_req       = '0;
        ram_req.raddr = idx_reg[ADDR_W-1:0];
        ram_req.waddr = chk_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (hb_in.valid)
                begin
                    if (hb_in.cmd == CMD_PULSE)
                    begin
                        if (id_in_range)
                        begin
                            ram_req.we    = 1'b1;
                            ram_req.waddr = hb_in.core_id[ADDR_W-1:0];
                            ram_req.wdata = hb_in.now;
                            valid_next[hb_in.core_id[ADDR_W-1:0]] = 1'b1;
                        end
                    end
                    else if (cfg.enable)
                    begin
                        now_next   = hb_in.now;
                        idx_next   = CNT_W'(1);
                        mask_next  = '0;
                        count_next = '0;
                        if (cfg.core_count > CCNT_W'(CORES))
                        begin
                            limit_next = CNT_W'(CORES);
                        end
                        else
                        begin
                            limit_next = cfg.core_count[CNT_W-1:0];
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (idx_reg < limit_reg)
                begin
                    ram_req.re   = 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = idx_reg[ADDR_W-1:0];
                    chk_hit_next = valid_reg[idx_reg[ADDR_W-1:0]];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else if (!chk_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || hb_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = mask_reg;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // write back a cleared stamp, during the next entry's read if any
        if (stale)
        begin
            ram_req.we    = 1'b1;
            ram_req.waddr = chk_idx_reg;
            ram_req.wdata = '0;
            valid_next[chk_idx_reg] = 1'b0;
            mask_next  = mask_reg | (MASK_W'(1) << chk_idx_reg);
            count_next = count_reg + FCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        limit_reg     <= limit_next;
        chk_hit_reg   <= chk_hit_next;
        chk_idx_reg   <= chk_idx_next;
        now_reg       <= now_next;
        mask_reg      <= mask_next;
        count_reg     <= count_next;
        out_mask_reg  <= out_mask_next;
        out_count_reg <= out_count_next;
    end

    a_chk_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_SCAN))
        else $error("entry check outside a scan");

    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
        else $error("read and write of the same table entry in one cycle");

    a_stale_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        stale |=> !valid_reg[$past(chk_idx_reg)])
        else $error("flagged entry still valid after clear");

    a_count_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (32'(count_reg) == $countones(mask_reg)))
        else $error("failure count disagrees with mask");

    a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> !chk_vld_reg)
        else $error("result formed with an entry check in flight");

endmodule

/* rtl/core/multicore_heartbeat_watchdog.sv */
// top level of the per-core heartbeat watchdog: config registers, sequencer, table ram
//
//  channel   dir   payload                        handshake
//  hb_in     in    cmd, core_id, now              valid / ready
//  hb_out    out   failed_mask, failed_count      valid / ready
//  cfg       in    cfg_index, cfg_wdata           cfg_we, no wait
//
// a pulse writes the stamp to the table ram
// a scan with limit = min(core_count, CORES) reads cores 1 to limit-1, a read per core,
// then does the last compare, a drain step and the result load, and takes the next
// request in the cycle after the load; with limit below two it reads no core
// a disabled scan is accepted and gives no result; reset clears the valid bits at once
// a waiting result does not block pulses; a finished scan holds until the result slot frees
module multicore_heartbeat_watchdog import hbwd_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    hbwd_in_if.sink              hb_in,
    hbwd_out_if.source           hb_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    cfg_t               cfg_reg;
    ram_req_t           ram_req;
    logic [STAMP_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= 1'b0;
            cfg_reg.threshold  <= THRESHOLD_RESET;
            cfg_reg.core_count <= CORE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENABLE:     cfg_reg.enable     <= cfg_wdata[0];
                REG_THRESHOLD:  cfg_reg.threshold  <= cfg_wdata[STAMP_W-1:0];
                REG_CORE_COUNT: cfg_reg.core_count <= cfg_wdata[CCNT_W-1:0];
                default:        ;
            endcase
        end
    end

    hbwd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .hb_in     (hb_in),
        .hb_out    (hb_out),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    hbwd_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (CORES)
    ) u_table (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule
